// ----- sv/kbm_pkg.sv -----
package kbm_pkg;

    localparam int PAT_TABLE_SIZE    = 36;
    localparam int PAT_TABLE_BYTES   = 10;
    localparam int PATTERN_COUNT_DEF = 36;
    localparam int MAX_LEN_DEF       = 10;
    localparam int RESULT_IDX_W      = 6;
    localparam int QUEUE_DEPTH       = 2;

    typedef logic [7:0] t_byte;

    // per-message verdict request handed from front to back
    typedef struct packed {
        logic                      exempt;
        logic [PAT_TABLE_SIZE-1:0] hits;
    } t_verdict_req;

    // ascii text, last character in the lowest byte
    localparam logic [8*PAT_TABLE_BYTES-1:0] PAT_TEXT [PAT_TABLE_SIZE] = '{
        80'h68747470_3a2f2f,
        80'h777777,
        80'h776f772d,
        80'h2d776f77,
        80'h7275,
        80'h6e6574,
        80'h6f7267,
        80'h636f6d,
        80'h62697a,
        80'h7a617074_6f,
        80'h6e6f2d69_70,
        80'h2e6c74,
        80'h6c6f68,
        80'h6a656261,
        80'h63697061,
        80'h67656a,
        80'h6377656c,
        80'h70697a64,
        80'h70696572_646f,
        80'h776f7773_74617273,
        80'h63617266_6167656e,
        80'h7265766f_6c757469_6f6e,
        80'h6172656e_612d776f_77,
        80'h776f7766_6c6167,
        80'h75776f77,
        80'h72697665_72726973_65,
        80'h6973656e_67617264,
        80'h776f7763_6972636c_65,
        80'h6a65742d_776f77,
        80'h776f772d_636f6f6c,
        80'h66616b65_776f77,
        80'h73707a6f_6e65,
        80'h776f7767_656172,
        80'h697a626f_6f73686b_61,
        80'h73697275_73,
        80'h656c6772_61636961
    };

    localparam int PAT_LEN [PAT_TABLE_SIZE] = '{
        7, 3, 4, 4, 2, 3, 3, 3, 3, 5, 5, 3,
        3, 4, 4, 3, 4, 4, 6, 8, 8, 10, 9, 7,
        4, 9, 8, 9, 7, 8, 7, 6, 7, 9, 5, 8
    };

    function automatic t_byte fold_case(input t_byte b);
        t_byte r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- sv/kbm_front.sv -----
module kbm_front #(
    parameter int PATTERN_COUNT   = kbm_pkg::PATTERN_COUNT_DEF,
    parameter int MAX_PATTERN_LEN = kbm_pkg::MAX_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  kbm_pkg::t_byte        i_byte,
    input  logic                  i_last,
    input  logic                  i_exempt,
    input  logic                  i_full,
    output logic                  o_push,
    output kbm_pkg::t_verdict_req o_req
);

    localparam int WIN   = MAX_PATTERN_LEN - 1;
    localparam int HIT_W = (PATTERN_COUNT < kbm_pkg::PAT_TABLE_SIZE) ?
                           PATTERN_COUNT : kbm_pkg::PAT_TABLE_SIZE;

    kbm_pkg::t_byte r_window [WIN];
    kbm_pkg::t_byte n_window [WIN];
    logic [HIT_W-1:0] r_hits;
    logic [HIT_W-1:0] n_hits;

    kbm_pkg::t_byte   w_cur;
    kbm_pkg::t_byte   w_tap [MAX_PATTERN_LEN];
    logic [HIT_W-1:0] w_match;
    logic             w_accept;

    assign w_cur    = kbm_pkg::fold_case(i_byte);
    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && i_last;

    assign o_req.exempt = i_exempt;
    assign o_req.hits   = kbm_pkg::PAT_TABLE_SIZE'(r_hits | w_match);

    assign w_tap[0] = w_cur;
    for (genvar k = 1; k < MAX_PATTERN_LEN; k++) begin : g_tap
        assign w_tap[k] = r_window[k-1];
    end

    // every pattern within PATTERN_COUNT that fits MAX_PATTERN_LEN compared in parallel, ending at the current byte
    for (genvar p = 0; p < HIT_W; p++) begin : g_pat
        if (kbm_pkg::PAT_LEN[p] <= MAX_PATTERN_LEN) begin : g_fit
            logic [kbm_pkg::PAT_LEN[p]-1:0] w_eq;
            for (genvar k = 0; k < kbm_pkg::PAT_LEN[p]; k++) begin : g_chr
                assign w_eq[k] = (w_tap[k] == kbm_pkg::PAT_TEXT[p][8*k +: 8]);
            end
            assign w_match[p] = &w_eq;
        end else begin : g_long
            assign w_match[p] = 1'b0;
        end
    end

    always_comb begin
        n_window = r_window;
        n_hits   = r_hits;
        if (w_accept) begin
            if (i_last) begin
                for (int k = 0; k < WIN; k++) begin
                    n_window[k] = '0;
                end
                n_hits = '0;
            end else begin
                n_window[0] = w_cur;
                for (int k = 1; k < WIN; k++) begin
                    n_window[k] = r_window[k-1];
                end
                n_hits = r_hits | w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_window[k] <= '0;
            end
            r_hits <= '0;
        end else begin
            r_window <= n_window;
            r_hits   <= n_hits;
        end
    end

    a_hits_clear_after_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_hits == '0 && r_window[0] == '0)
    ) else $error("hit bits not cleared after message end");

    a_push_has_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_ready && !i_full)
    ) else $error("verdict pushed into a full queue");

endmodule

// ----- sv/kbm_queue.sv -----
module kbm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  kbm_pkg::t_verdict_req i_req,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output kbm_pkg::t_verdict_req o_req
);

    localparam int DEPTH = kbm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kbm_pkg::t_verdict_req r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)
    ) else $error("queue count beyond depth");

    a_no_pop_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid
    ) else $error("pop from empty queue");

endmodule

// ----- sv/kbm_back.sv -----
module kbm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  kbm_pkg::t_verdict_req             i_req,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_blocked,
    output logic [kbm_pkg::RESULT_IDX_W-1:0]  o_first
);

    localparam int IDX_W = kbm_pkg::RESULT_IDX_W;

    logic             r_valid;
    logic             r_blocked;
    logic [IDX_W-1:0] r_first;
    logic [IDX_W-1:0] w_idx;
    logic             w_blocked;

    assign o_pop     = i_q_valid && (!r_valid || i_ready);
    assign w_blocked = !i_req.exempt && (i_req.hits != '0);

    always_comb begin
        w_idx = '0;
        for (int p = kbm_pkg::PAT_TABLE_SIZE - 1; p >= 0; p--) begin
            if (i_req.hits[p]) begin
                w_idx = IDX_W'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blocked <= w_blocked;
            r_first   <= w_blocked ? w_idx : '0;
        end
    end

    assign o_valid   = r_valid;
    assign o_blocked = r_blocked;
    assign o_first   = r_first;

    a_first_zero_when_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_blocked) |-> (r_first == '0)
    ) else $error("pattern index set on a clean message");

endmodule

// ----- sv/keyword_blocklist_matcher_unit.sv -----
// keyword blocklist matcher
// input stream s_axis: one chat message byte per transaction, tlast on the
// final byte, tuser carries the two exemption flags sampled on that byte.
// output stream m_axis: one verdict transaction per message, nothing for
// the other bytes.
// a byte is folded to lower case and compared, together with the window of
// preceding bytes, against the fixed dictionary combinationally; hits stick
// until message end, then window and hits clear.
// throughput: one byte per cycle while the verdict queue is not full.
// after the last byte is accepted the verdict is written into the verdict
// queue, then passes the encoder into the output register onto m_axis.
// a two-entry verdict queue separates the byte front end from the output
// stage, so the front keeps taking bytes while a verdict waits on m_axis;
// s_axis_tready drops only when both queue entries are held by a stalled
// receiver.
// reset (synchronous, active low) clears the window, hits, queue and output
// valid; bytes are accepted on the first cycle after reset.
module keyword_blocklist_matcher_unit #(
    parameter int PATTERN_COUNT   = kbm_pkg::PATTERN_COUNT_DEF,
    parameter int MAX_PATTERN_LEN = kbm_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] message_byte
    input  logic       s_axis_tlast,
    input  logic [1:0] s_axis_tuser,   // [0] privileged_sender, [1] addon_language
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] blocked, [6:1] first_pattern, [7] zero
);

    logic                              w_full;
    logic                              w_push;
    kbm_pkg::t_verdict_req             w_push_req;
    logic                              w_q_valid;
    logic                              w_pop;
    kbm_pkg::t_verdict_req             w_head_req;
    logic                              w_blocked;
    logic [kbm_pkg::RESULT_IDX_W-1:0]  w_first;

    kbm_front #(
        .PATTERN_COUNT   (PATTERN_COUNT),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_exempt (s_axis_tuser[0] || s_axis_tuser[1]),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_req    (w_push_req)
    );

    kbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_req   (w_head_req)
    );

    kbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_req     (w_head_req),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_blocked (w_blocked),
        .o_first   (w_first)
    );

    assign m_axis_tdata = {1'b0, w_first, w_blocked};

endmodule
